// ===== rtl/parked_sleep_decider_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Parked sleep decider assertion macros
// Concurrent check wrappers; empty when built for synthesis.
// ---------------------------------------------------------------------------
`ifndef PARKED_SLEEP_DECIDER_UNIT_MACROS_SVH
`define PARKED_SLEEP_DECIDER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define PSD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("parked sleep decider check failed");

`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("parked sleep decider check failed");

`else

`define PSD_ASSERT_NOW(label, clk, rst, ante, cons)

`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/psd_pkg.sv =====
// ---------------------------------------------------------------------------
// Parked sleep decider package
// Word types, operation and decision codes, register map and bounds.
// ---------------------------------------------------------------------------
package psd_pkg;

  // operation codes
  localparam logic [3:0] OP_START    = 4'd0;
  localparam logic [3:0] OP_TICK     = 4'd1;
  localparam logic [3:0] OP_IGNITION = 4'd2;
  localparam logic [3:0] OP_PRIMARY  = 4'd3;
  localparam logic [3:0] OP_BUSY     = 4'd4;
  localparam logic [3:0] OP_BEGIN    = 4'd5;
  localparam logic [3:0] OP_DEFER    = 4'd6;
  localparam logic [3:0] OP_FINISH   = 4'd7;
  localparam logic [3:0] OP_PENDING  = 4'd8;

  // decision codes
  localparam logic [1:0] DEC_AWAKE       = 2'd0;
  localparam logic [1:0] DEC_IGN_OFF     = 2'd1;
  localparam logic [1:0] DEC_IGN_UNKNOWN = 2'd2;
  localparam logic [1:0] DEC_BOOT_PROBE  = 2'd3;

  localparam logic [2:0] WAKE_POWER_ON = 3'd0;

  // register indexes
  localparam logic [2:0] REG_AVAILABLE = 3'd0;
  localparam logic [2:0] REG_ENABLED   = 3'd1;
  localparam logic [2:0] REG_HOLD      = 3'd2;
  localparam logic [2:0] REG_WAKE      = 3'd3;
  localparam logic [2:0] REG_DELAY     = 3'd4;
  localparam logic [2:0] REG_GRACE     = 3'd5;

  localparam logic [19:0] DELAY_MIN   = 20'd5000;
  localparam logic [19:0] DELAY_MAX   = 20'd600000;
  localparam logic [19:0] DELAY_RESET = 20'd60000;
  localparam logic [19:0] GRACE_MIN   = 20'd30000;
  localparam logic [19:0] GRACE_MAX   = 20'd600000;
  localparam logic [19:0] GRACE_RESET = 20'd30000;

  typedef struct packed {
    logic        available;
    logic        enabled;
    logic        hold;
    logic [2:0]  wake_reason;
    logic [19:0] sleep_delay;
    logic [19:0] grace_period;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  operation;
    logic [31:0] now_ms;
    logic        busy_req;
    logic        ign_is_on;
    logic [7:0]  ign_src_id;
    logic        probe_pending;
  } event_word_t;

  typedef struct packed {
    logic [1:0]  decision;
    logic        sleep_granted;
    logic        is_active;
    logic        ign_reported;
    logic        ignition_level;
    logic        ignition_recent;
    logic        sleep_entering;
    logic        probe_pending_flag;
    logic [7:0]  last_source;
    logic [31:0] primary_age_ms;
    logic [31:0] ignition_on_age_ms;
    logic [31:0] ignition_off_age_ms;
  } result_word_t;

endpackage

// ===== rtl/psd_cfg.sv =====
// ---------------------------------------------------------------------------
// Parked sleep decider register file
// APB-style policy registers; delay and grace writes clamp to their bounds.
// ---------------------------------------------------------------------------
module psd_cfg import psd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic        wr_en;
  logic [2:0]  reg_index;
  logic [19:0] wdata_low;
  logic [19:0] delay_clamped;
  logic [19:0] grace_clamped;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[4:2];
  assign wdata_low = pwdata[19:0];

  always_comb begin
    if (wdata_low < DELAY_MIN) begin
      delay_clamped = DELAY_MIN;
    end else if (wdata_low > DELAY_MAX) begin
      delay_clamped = DELAY_MAX;
    end else begin
      delay_clamped = wdata_low;
    end
    if (wdata_low < GRACE_MIN) begin
      grace_clamped = GRACE_MIN;
    end else if (wdata_low > GRACE_MAX) begin
      grace_clamped = GRACE_MAX;
    end else begin
      grace_clamped = wdata_low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.available    <= 1'b0;
      cfg.enabled      <= 1'b0;
      cfg.hold         <= 1'b0;
      cfg.wake_reason  <= WAKE_POWER_ON;
      cfg.sleep_delay  <= DELAY_RESET;
      cfg.grace_period <= GRACE_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_AVAILABLE: cfg.available    <= pwdata[0];
        REG_ENABLED:   cfg.enabled      <= pwdata[0];
        REG_HOLD:      cfg.hold         <= pwdata[0];
        REG_WAKE:      cfg.wake_reason  <= pwdata[2:0];
        REG_DELAY:     cfg.sleep_delay  <= delay_clamped;
        REG_GRACE:     cfg.grace_period <= grace_clamped;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_AVAILABLE: prdata = {31'd0, cfg.available};
      REG_ENABLED:   prdata = {31'd0, cfg.enabled};
      REG_HOLD:      prdata = {31'd0, cfg.hold};
      REG_WAKE:      prdata = {29'd0, cfg.wake_reason};
      REG_DELAY:     prdata = {12'd0, cfg.sleep_delay};
      REG_GRACE:     prdata = {12'd0, cfg.grace_period};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/parked_sleep_decider_unit.sv =====
// ---------------------------------------------------------------------------
// Parked sleep decider unit
// Decides stay awake or a sleep reason from timestamped vehicle events.
// ---------------------------------------------------------------------------
// Usage:
//   event channel  : event_valid / event_stall / event_word, one event a word.
//   result channel : result_valid / result_stall / result_word, one result
//                    word for every event word, in order.
//   APB port       : policy registers at byte address 4*i; pready is tied
//                    high. Write them while no event is in flight, then issue
//                    a start event.
// Timing: an event is captured in the input register at the accepting edge,
//   evaluated against the stored times and flags, and written to the result
//   register at an edge where result_stall holds no result, which raises
//   result_valid. One event per cycle is sustained while nothing stalls;
//   the state update and the 32-bit age subtract/compare path between the
//   two registers set that figure.
// Reset: all stored times read as never, flags clear, registers return to
//   their defaults (inactive, sleep delay 60000 ms, grace 30000 ms).
// Stall: while result_stall holds a result, the input register holds too
//   and event_stall rises once it is full; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "parked_sleep_decider_unit_macros.svh"

module parked_sleep_decider_unit import psd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         event_valid,
  output logic         event_stall,
  input  event_word_t  event_word,
  output logic         result_valid,
  input  logic         result_stall,
  output result_word_t result_word,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t         cfg;
  logic         s1_valid;
  event_word_t  s1_word;
  logic         advance;
  logic         process;
  result_word_t result_next;

  logic [31:0] boot_time, awake_time, primary_time, ign_on_time, ign_off_time;
  logic [31:0] boot_time_next, awake_time_next, primary_time_next;
  logic [31:0] ign_on_time_next, ign_off_time_next;
  logic        seen_bit, level_bit, sleeping_bit, pending_bit;
  logic        seen_bit_next, level_bit_next, sleeping_bit_next, pending_bit_next;
  logic [7:0]  source_reg, source_reg_next;

  logic        is_on;
  logic        in_grace;
  logic        recent_pre;
  logic        recent_post;
  logic        idle_done;
  logic [31:0] now;
  logic [31:0] boot_elapsed, awake_elapsed, on_elapsed_pre, on_elapsed_post;
  logic [1:0]  decision;
  logic        granted;

  psd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance     = !result_valid || !result_stall;
  assign process     = s1_valid && advance;
  assign event_stall = s1_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!event_stall) begin
      s1_valid <= event_valid;
    end
    if (!event_stall && event_valid) begin
      s1_word <= event_word;
    end
  end

  assign now             = s1_word.now_ms;
  assign is_on           = cfg.available && cfg.enabled && !cfg.hold;
  assign boot_elapsed    = now - boot_time;
  assign awake_elapsed   = now - awake_time;
  assign on_elapsed_pre  = now - ign_on_time;
  assign on_elapsed_post = now - ign_on_time_next;
  assign in_grace        = (cfg.wake_reason == WAKE_POWER_ON) &&
                           (boot_elapsed < {12'd0, cfg.grace_period});
  assign recent_pre      = level_bit && (ign_on_time != 32'd0) &&
                           (on_elapsed_pre <= {12'd0, cfg.sleep_delay});
  assign recent_post     = level_bit_next && (ign_on_time_next != 32'd0) &&
                           (on_elapsed_post <= {12'd0, cfg.sleep_delay});
  assign idle_done       = awake_elapsed >= {12'd0, cfg.sleep_delay};

  always_comb begin
    boot_time_next    = boot_time;
    awake_time_next   = awake_time;
    primary_time_next = primary_time;
    ign_on_time_next  = ign_on_time;
    ign_off_time_next = ign_off_time;
    seen_bit_next     = seen_bit;
    level_bit_next    = level_bit;
    source_reg_next   = source_reg;
    sleeping_bit_next = sleeping_bit;
    pending_bit_next  = pending_bit;
    decision          = DEC_AWAKE;
    granted           = 1'b0;
    case (s1_word.operation)
      OP_START: begin
        pending_bit_next  = 1'b0;
        sleeping_bit_next = 1'b0;
        boot_time_next    = now;
        awake_time_next   = now;
        primary_time_next = 32'd0;
        seen_bit_next     = 1'b0;
        level_bit_next    = 1'b0;
        source_reg_next   = 8'd0;
        ign_on_time_next  = 32'd0;
        ign_off_time_next = 32'd0;
      end
      OP_TICK: begin
        if (!sleeping_bit) begin
          if (!is_on) begin
            awake_time_next = now;
          end else if (!in_grace) begin
            if (s1_word.busy_req) begin
              awake_time_next = now;
            end else if (!recent_pre && idle_done) begin
              decision = seen_bit ? DEC_IGN_OFF : DEC_IGN_UNKNOWN;
            end
          end
        end
      end
      OP_IGNITION: begin
        seen_bit_next   = 1'b1;
        level_bit_next  = s1_word.ign_is_on;
        source_reg_next = s1_word.ign_src_id;
        if (s1_word.ign_is_on) begin
          ign_on_time_next = now;
          awake_time_next  = now;
        end else begin
          ign_off_time_next = now;
        end
      end
      OP_PRIMARY: primary_time_next = now;
      OP_BUSY:    awake_time_next = now;
      OP_BEGIN: begin
        granted           = !sleeping_bit;
        sleeping_bit_next = 1'b1;
      end
      OP_DEFER: begin
        awake_time_next   = now;
        sleeping_bit_next = 1'b0;
      end
      OP_FINISH: begin
        pending_bit_next = 1'b0;
        if (is_on && !recent_pre && !in_grace) begin
          decision = DEC_BOOT_PROBE;
        end
      end
      OP_PENDING: pending_bit_next = s1_word.probe_pending;
      default: ;
    endcase

    result_next.decision            = decision;
    result_next.sleep_granted       = granted;
    result_next.is_active           = is_on;
    result_next.ign_reported        = seen_bit_next;
    result_next.ignition_level      = level_bit_next;
    result_next.ignition_recent     = recent_post;
    result_next.sleep_entering      = sleeping_bit_next;
    result_next.probe_pending_flag  = pending_bit_next;
    result_next.last_source         = source_reg_next;
    result_next.primary_age_ms      = (primary_time_next == 32'd0) ? 32'd0 :
                                      now - primary_time_next;
    result_next.ignition_on_age_ms  = (ign_on_time_next == 32'd0) ? 32'd0 :
                                      on_elapsed_post;
    result_next.ignition_off_age_ms = (ign_off_time_next == 32'd0) ? 32'd0 :
                                      now - ign_off_time_next;
  end

  // stored state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      boot_time    <= 32'd0;
      awake_time   <= 32'd0;
      primary_time <= 32'd0;
      ign_on_time  <= 32'd0;
      ign_off_time <= 32'd0;
      seen_bit     <= 1'b0;
      level_bit    <= 1'b0;
      source_reg   <= 8'd0;
      sleeping_bit <= 1'b0;
      pending_bit  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (process) begin
        boot_time    <= boot_time_next;
        awake_time   <= awake_time_next;
        primary_time <= primary_time_next;
        ign_on_time  <= ign_on_time_next;
        ign_off_time <= ign_off_time_next;
        seen_bit     <= seen_bit_next;
        level_bit    <= level_bit_next;
        source_reg   <= source_reg_next;
        sleeping_bit <= sleeping_bit_next;
        pending_bit  <= pending_bit_next;
      end
      if (advance) begin
        result_valid <= s1_valid;
      end
    end
    if (process) begin
      result_word <= result_next;
    end
  end

  `PSD_ASSERT_NEXT(a_process_fills_result, clk, rst, process, result_valid)
  `PSD_ASSERT_NOW(a_stall_only_when_full, clk, rst, event_stall, s1_valid)
  `PSD_ASSERT_NOW(a_sleep_needs_active, clk, rst,
                  result_valid && (result_word.decision != DEC_AWAKE),
                  result_word.is_active)
  `PSD_ASSERT_NOW(a_grant_sets_flag, clk, rst,
                  result_valid && result_word.sleep_granted,
                  result_word.sleep_entering)

endmodule
